>>> rtl/core/crtc_pkg.sv
// Shared types and constants of the cartridge real-time clock advance block.
// Used by crtc_tick_unit and cartridge_rtc_second_advance; depends on nothing.
package crtc_pkg;

  localparam int ADVANCE_WIDTH = 16;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 8;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RTC_KIND      = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CLOCK_STOPPED = 2'd1;

  localparam logic [1:0] KIND_DAY    = 2'd0;
  localparam logic [1:0] KIND_MINUTE = 2'd1;
  localparam logic [1:0] KIND_WEEK   = 2'd2;

  localparam logic [63:0] EPOCH_SECONDS      = 64'd946684800;
  localparam logic [5:0]  LAST_PHASE         = 6'd59;
  localparam logic [7:0]  SECONDS_PER_MINUTE = 8'd60;
  localparam logic [7:0]  MINUTES_PER_HOUR   = 8'd60;
  localparam logic [7:0]  HOURS_PER_DAY      = 8'd24;
  localparam logic [2:0]  DAYS_PER_WEEK      = 3'd7;
  localparam logic [10:0] MINUTES_PER_DAY    = 11'd1440;

  typedef struct packed {
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hour;
    logic [8:0]  day;
    logic        day_carry;
    logic [2:0]  weekday;
    logic [7:0]  week;
    logic        week_overflow;
    logic [10:0] minute_of_day;
    logic [15:0] long_day;
    logic [63:0] elapsed;
    logic [5:0]  minute_phase;
  } clock_state_t;

  typedef struct packed {
    logic tick;
    logic minute_mode;
    logic week_mode;
  } tick_ctrl_t;

endpackage

>>> rtl/core/crtc_tick_unit.sv
// Clock state registers and the shared one-second increment unit.
// Depends on crtc_pkg.
module crtc_tick_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  crtc_pkg::tick_ctrl_t   ctrl,
  output crtc_pkg::clock_state_t state
);
  import crtc_pkg::*;

  clock_state_t state_next;
  logic [7:0]   sec_inc;
  logic [7:0]   min_inc;
  logic [7:0]   hour_inc;
  logic [2:0]   weekday_inc;
  logic [10:0]  mod_inc;

  assign sec_inc     = state.sec + 8'd1;
  assign min_inc     = state.min + 8'd1;
  assign hour_inc    = state.hour + 8'd1;
  assign weekday_inc = state.weekday + 3'd1;
  assign mod_inc     = state.minute_of_day + 11'd1;

  always_comb begin
    state_next = state;
    if (ctrl.tick) begin
      state_next.elapsed = state.elapsed + 64'd1;
      if (state.minute_phase == LAST_PHASE) begin
        state_next.minute_phase = 6'd0;
      end else begin
        state_next.minute_phase = state.minute_phase + 6'd1;
      end
      if (ctrl.minute_mode) begin
        if (state.minute_phase == LAST_PHASE) begin
          if (mod_inc == MINUTES_PER_DAY) begin
            state_next.minute_of_day = 11'd0;
            state_next.long_day      = state.long_day + 16'd1;
          end else begin
            state_next.minute_of_day = mod_inc;
          end
        end
      end else if (sec_inc != SECONDS_PER_MINUTE) begin
        state_next.sec = sec_inc;
      end else begin
        state_next.sec = 8'd0;
        if (min_inc != MINUTES_PER_HOUR) begin
          state_next.min = min_inc;
        end else begin
          state_next.min = 8'd0;
          if (hour_inc != HOURS_PER_DAY) begin
            state_next.hour = hour_inc;
          end else begin
            state_next.hour = 8'd0;
            if (ctrl.week_mode) begin
              if (weekday_inc != DAYS_PER_WEEK) begin
                state_next.weekday = weekday_inc;
              end else begin
                state_next.weekday = 3'd0;
                state_next.week    = state.week + 8'd1;
                if (state.week == 8'hFF) begin
                  state_next.week_overflow = 1'b1;
                end
              end
            end else begin
              state_next.day = state.day + 9'd1;
              if (state.day == 9'h1FF) begin
                state_next.day_carry = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{elapsed: EPOCH_SECONDS, default: '0};
    end else begin
      state <= state_next;
    end
  end

  // The phase counter tracks the elapsed count modulo one minute.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    state.minute_phase <= LAST_PHASE)
    else $error("minute phase out of range");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    state.sec < SECONDS_PER_MINUTE && state.weekday < DAYS_PER_WEEK &&
    state.minute_of_day < MINUTES_PER_DAY)
    else $error("time counter out of range");

  a_hold_idle: assert property (@(posedge clk) disable iff (rst)
    !ctrl.tick |=> $stable(state))
    else $error("clock state moved without a tick");

endmodule

>>> rtl/core/cartridge_rtc_second_advance.sv
// Top level of the cartridge real-time clock advance block: sequencer,
// configuration registers and result register. Depends on crtc_pkg and crtc_tick_unit.
//
// An item asking for N seconds is accepted in ST_IDLE; in ST_RUN the shared increment
// unit advances the clock one second for each of the N seconds, and ST_DONE moves the
// final state into the result register once that register is free. A zero
// advance, or a stopped day or week clock, goes from ST_IDLE straight to ST_DONE.
// advance_count is 16 bits wide. The input is not ready while an item is in
// progress; the result register lets the next item be taken while a result still waits.
module cartridge_rtc_second_advance (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [crtc_pkg::ADVANCE_WIDTH-1:0]   advance_count,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           sec_value,
  output logic [7:0]                           min_value,
  output logic [7:0]                           hour_value,
  output logic [8:0]                           day_value,
  output logic                                 day_carry_flag,
  output logic [2:0]                           weekday_value,
  output logic [7:0]                           week_value,
  output logic                                 week_overflow_flag,
  output logic [10:0]                          minute_of_day,
  output logic [15:0]                          long_day_count,
  output logic [63:0]                          elapsed_seconds,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [crtc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [crtc_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
  import crtc_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } seq_state_t;

  seq_state_t               seq;
  logic [ADVANCE_WIDTH-1:0] remaining;
  logic [1:0]               rtc_kind;
  logic                     clock_stopped;
  logic                     run_enable;
  logic                     load_result;
  tick_ctrl_t               ctrl;
  clock_state_t             clk_state;
  clock_state_t             result;

  assign cfg_ready   = 1'b1;
  assign in_ready    = (seq == ST_IDLE);
  assign run_enable  = (rtc_kind == KIND_MINUTE) || !clock_stopped;
  assign load_result = (seq == ST_DONE) && (!out_valid || out_ready);

  assign ctrl.tick        = (seq == ST_RUN);
  assign ctrl.minute_mode = (rtc_kind == KIND_MINUTE);
  assign ctrl.week_mode   = (rtc_kind == KIND_WEEK);

  crtc_tick_unit u_tick (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .state (clk_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rtc_kind      <= KIND_DAY;
      clock_stopped <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RTC_KIND:      rtc_kind      <= cfg_data[1:0];
        CFG_CLOCK_STOPPED: clock_stopped <= cfg_data[0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq       <= ST_IDLE;
      out_valid <= 1'b0;
      remaining <= '0;
    end else begin
      if (load_result) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (seq)
        ST_IDLE: begin
          if (in_valid) begin
            remaining <= advance_count;
            if (advance_count == '0 || !run_enable) begin
              seq <= ST_DONE;
            end else begin
              seq <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          remaining <= remaining - ADVANCE_WIDTH'(1);
          if (remaining == {{(ADVANCE_WIDTH-1){1'b0}}, 1'b1}) begin
            seq <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_result) begin
            result <= clk_state;
            seq    <= ST_IDLE;
          end
        end
        default: seq <= ST_IDLE;
      endcase
    end
  end

  assign sec_value          = result.sec;
  assign min_value          = result.min;
  assign hour_value         = result.hour;
  assign day_value          = result.day;
  assign day_carry_flag     = result.day_carry;
  assign weekday_value      = result.weekday;
  assign week_value         = result.week;
  assign week_overflow_flag = result.week_overflow;
  assign minute_of_day      = result.minute_of_day;
  assign long_day_count     = result.long_day;
  assign elapsed_seconds    = result.elapsed;

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    seq == ST_RUN |-> remaining != '0)
    else $error("running with no seconds left");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input still ready after an item was taken");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(seq) == ST_DONE)
    else $error("result raised outside the finish step");

endmodule
